@@ rtl/core/spo2_ratio_estimator_core_defines.svh @@
// Assertion macros shared by the SpO2 ratio estimator RTL.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef SPO2_RATIO_ESTIMATOR_CORE_DEFINES_SVH
`define SPO2_RATIO_ESTIMATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPO2_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPO2_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/spo2_pkg.sv @@
// Package for the SpO2 ratio estimator: widths, fixed-point constants,
// register indexes and the configuration struct. No dependencies.
`default_nettype none
package spo2_pkg;

	localparam int SAMPLE_W = 18;
	localparam int DC_W = 34;
	localparam int ENERGY_W = 56;
	localparam int ROOT_W = 28;
	localparam int D4_W = 23;
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 29;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int NUM_W = 62;
	localparam int RATIO_W = 16;
	localparam int SPO2_W = 16;
	localparam int RAW_W = 18;
	localparam int COEFF_W = 16;
	localparam int THR_W = 18;
	localparam int WLEN_W = 11;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam int DEF_SAMPLE_BITS = 18;
	localparam int DEF_MAX_WINDOW = 1024;

	localparam logic [COEFF_W-1:0] RST_DC_COEFF = 16'd62259;
	localparam logic [COEFF_W-1:0] RST_SMOOTH_COEFF = 16'd45875;
	localparam logic [THR_W-1:0] RST_FINGER_THR = 18'd30000;
	localparam logic [WLEN_W-1:0] RST_WINDOW_LEN = 11'd100;

	localparam logic signed [RAW_W-1:0] Q12_POINT_FOUR = 18'sd1638;
	localparam logic signed [MUL_B_W-1:0] Q12_SLOPE = 29'sd95437;
	localparam logic signed [RAW_W-1:0] Q8_HUNDRED = 18'sd25600;

	typedef enum logic [1:0] {
		REG_DC_COEFF,
		REG_SMOOTH_COEFF,
		REG_FINGER_THR,
		REG_WINDOW_LEN
	} reg_idx_t;

	typedef struct packed {
		logic [COEFF_W-1:0] dc_coeff;
		logic [COEFF_W-1:0] smooth_coeff;
		logic [THR_W-1:0] finger_threshold;
		logic [WLEN_W-1:0] window_len;
	} cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/spo2_if.sv @@
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on spo2_pkg for the field widths.
`default_nettype none
interface spo2_in_if;
	import spo2_pkg::*;
	logic valid;
	logic ready;
	logic [SAMPLE_W-1:0] red_sample;
	logic [SAMPLE_W-1:0] ir_sample;
	modport source(output valid, red_sample, ir_sample, input ready);
	modport sink(input valid, red_sample, ir_sample, output ready);
endinterface

interface spo2_out_if;
	import spo2_pkg::*;
	logic valid;
	logic ready;
	logic window_end;
	logic finger_off;
	logic estimate_valid;
	logic divide_fault;
	logic [RATIO_W-1:0] ratio_value;
	logic signed [SPO2_W-1:0] spo2_estimate;
	modport source(output valid, window_end, finger_off, estimate_valid, divide_fault,
		ratio_value, spo2_estimate, input ready);
	modport sink(input valid, window_end, finger_off, estimate_valid, divide_fault,
		ratio_value, spo2_estimate, output ready);
endinterface
`default_nettype wire

@@ rtl/core/spo2_ratio_estimator_core.sv @@
// Top level of the SpO2 ratio-of-ratios estimator: sequencer around one shared
// multiplier. Uses spo2_pkg, spo2_if, spo2_regs, spo2_sqrt, spo2_div and the defines.
//
//   Channel   Direction  Transfer        Payload
//   smp       in         valid & ready   red_sample, ir_sample
//   res       out        valid & ready   window_end .. spo2_estimate
//   APB       in         psel & penable  dc_coeff, smooth_coeff, finger_threshold, window_len
//
// A sample that does not close a window goes through the DC and energy updates only.
// A finger-present window end adds two square roots on the shared root unit,
// a division, five passes through the multiplier and the bookkeeping states.
// The next sample is taken once the result is in the output register.
// Reset clears all filter state; the registers take their default values.
`default_nettype none
`include "spo2_ratio_estimator_core_defines.svh"
module spo2_ratio_estimator_core #(
	parameter int SAMPLE_BITS = spo2_pkg::DEF_SAMPLE_BITS,
	parameter int MAX_WINDOW = spo2_pkg::DEF_MAX_WINDOW
) (
	input  logic                            clk,
	input  logic                            arst_n,
	spo2_in_if.sink                         smp,
	spo2_out_if.source                      res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spo2_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [spo2_pkg::APB_DATA_W-1:0] pwdata,
	output logic [spo2_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import spo2_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int DC_DROP = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS - SAMPLE_W : 0;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
		SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	typedef enum logic [4:0] {
		S_IDLE, S_DCR_A, S_DCR_B, S_DCR_C, S_DCI_B, S_DCI_C, S_EN_R, S_EN_I,
		S_EN_DONE, S_SQR_GO, S_SQR_WAIT, S_SQI_GO, S_SQI_WAIT, S_FCHK, S_MUL_D,
		S_DIV_GO, S_DIV_WAIT, S_RAW_A, S_RAW_B, S_SM_A, S_SM_B, S_SM_C, S_OUT
	} state_t;

	function automatic logic [D4_W-1:0] dev_q4(input logic [SAMPLE_W-1:0] s,
			input logic [DC_W-1:0] dc);
		logic [DC_W-1:0] x;
		logic [DC_W-1:0] dv;
		logic [DC_W:0] r;
		x = {s, 16'b0};
		dv = (x >= dc) ? x - dc : dc - x;
		r = {1'b0, dv} + (DC_W + 1)'(2048);
		return r[DC_W:12];
	endfunction

	cfg_t cfg;
	state_t state_q;

	logic [SAMPLE_W-1:0] red_q, ir_q;
	logic [CNT_W-1:0] len_q, len_c, count_q;
	logic [CNT_W:0] cnt_next;
	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic [D4_W-1:0] d4_q;
	logic [DC_W-1:0] red_dc_q, ir_dc_q, dcr, dci;
	logic [ENERGY_W-1:0] red_e_q, ir_e_q;
	logic [ROOT_W-1:0] sr_q, si_q;
	logic [RATIO_W-1:0] ratio_q;
	logic signed [RAW_W-1:0] raw_q, t_val, raw_next;
	logic signed [SPO2_W-1:0] smooth_q;
	logic wend_q, foff_q, valid_q, fault_q;

	logic out_valid_q, out_wend_q, out_foff_q, out_est_q, out_fault_q;
	logic [RATIO_W-1:0] out_ratio_q;
	logic signed [SPO2_W-1:0] out_spo2_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic [16:0] dc_inv, sm_inv;
	logic signed [PROD_W-1:0] dc_sum, sm_sum, sm_shr, rnd;
	logic [DC_W-1:0] dc_new;
	logic [ENERGY_W:0] e_sum;
	logic [ENERGY_W-1:0] e_new;
	logic [SAMPLE_W-1:0] d4_src;
	logic [DC_W-1:0] d4_dc;
	logic sq_start, sq_done, dv_start, dv_done;
	logic [ENERGY_W-1:0] sq_in;
	logic [ROOT_W-1:0] sq_root;
	logic [RATIO_W-1:0] dv_quo;
	logic accept;

	spo2_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	spo2_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_in),
		.done(sq_done), .root(sq_root)
	);

	spo2_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(acc_q[NUM_W-1:0]),
		.den(prod_q[NUM_W-1:0]), .done(dv_done), .quo(dv_quo)
	);

	assign smp.ready = (state_q == S_IDLE);
	assign accept = smp.valid && smp.ready;
	assign res.valid = out_valid_q;
	assign res.window_end = out_wend_q;
	assign res.finger_off = out_foff_q;
	assign res.estimate_valid = out_est_q;
	assign res.divide_fault = out_fault_q;
	assign res.ratio_value = out_ratio_q;
	assign res.spo2_estimate = out_spo2_q;

	assign sq_start = (state_q == S_SQR_GO) || (state_q == S_SQI_GO);
	assign sq_in = (state_q == S_SQR_GO) ? red_e_q : ir_e_q;
	assign dv_start = (state_q == S_DIV_GO);

	assign dc_inv = 17'h10000 - 17'(cfg.dc_coeff);
	assign sm_inv = 17'h10000 - 17'(cfg.smooth_coeff);
	assign dcr = red_dc_q >> DC_DROP;
	assign dci = ir_dc_q >> DC_DROP;
	assign t_val = $signed({2'b0, ratio_q}) - Q12_POINT_FOUR;
	assign cnt_next = {1'b0, count_q} + (CNT_W + 1)'(1);

	always_comb begin
		if (cfg.window_len == '0) begin
			len_c = CNT_W'(1);
		end else if (32'(cfg.window_len) > MAX_WINDOW) begin
			len_c = CNT_W'(MAX_WINDOW);
		end else begin
			len_c = CNT_W'(cfg.window_len);
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_DCR_A: begin
				mul_a = $signed({1'b0, red_dc_q});
				mul_b = $signed(MUL_B_W'(cfg.dc_coeff));
			end
			S_DCR_B: begin
				mul_a = $signed(MUL_A_W'(red_q));
				mul_b = $signed(MUL_B_W'(dc_inv));
			end
			S_DCR_C: begin
				mul_a = $signed({1'b0, ir_dc_q});
				mul_b = $signed(MUL_B_W'(cfg.dc_coeff));
			end
			S_DCI_B: begin
				mul_a = $signed(MUL_A_W'(ir_q));
				mul_b = $signed(MUL_B_W'(dc_inv));
			end
			S_EN_R, S_EN_I: begin
				mul_a = $signed(MUL_A_W'(d4_q));
				mul_b = $signed(MUL_B_W'(d4_q));
			end
			S_FCHK: begin
				mul_a = $signed({1'b0, dci});
				mul_b = $signed(MUL_B_W'(sr_q));
			end
			S_MUL_D: begin
				mul_a = $signed({1'b0, dcr});
				mul_b = $signed(MUL_B_W'(si_q));
			end
			S_RAW_A: begin
				mul_a = MUL_A_W'(t_val);
				mul_b = Q12_SLOPE;
			end
			S_SM_A: begin
				mul_a = $signed(MUL_A_W'(cfg.smooth_coeff));
				mul_b = MUL_B_W'(smooth_q);
			end
			S_SM_B: begin
				mul_a = MUL_A_W'(raw_q);
				mul_b = $signed(MUL_B_W'(sm_inv));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign dc_sum = acc_q + (prod_q <<< 16) + PROD_W'(32768);
	assign dc_new = dc_sum[DC_W+15:16];
	assign e_sum = (state_q == S_EN_I) ? {1'b0, red_e_q} + (ENERGY_W + 1)'(prod_q[45:0])
		: {1'b0, ir_e_q} + (ENERGY_W + 1)'(prod_q[45:0]);
	assign e_new = e_sum[ENERGY_W] ? '1 : e_sum[ENERGY_W-1:0];
	assign rnd = (prod_q + PROD_W'(32768)) >>> 16;
	assign raw_next = Q8_HUNDRED - $signed(rnd[RAW_W-1:0]);
	assign sm_sum = acc_q + prod_q + PROD_W'(32768);
	assign sm_shr = sm_sum >>> 16;
	assign d4_src = (state_q == S_DCI_C) ? red_q : ir_q;
	assign d4_dc = (state_q == S_DCI_C) ? red_dc_q : ir_dc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			red_dc_q <= '0;
			ir_dc_q <= '0;
			red_e_q <= '0;
			ir_e_q <= '0;
			count_q <= '0;
			smooth_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			prod_q <= mul_a * mul_b;
			if (out_valid_q && res.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						red_q <= smp.red_sample & SAMPLE_MASK;
						ir_q <= smp.ir_sample & SAMPLE_MASK;
						len_q <= len_c;
						ratio_q <= '0;
						wend_q <= 1'b0;
						foff_q <= 1'b0;
						valid_q <= 1'b0;
						fault_q <= 1'b0;
						state_q <= S_DCR_A;
					end
				end
				S_DCR_A: state_q <= S_DCR_B;
				S_DCR_B: begin
					acc_q <= prod_q;
					state_q <= S_DCR_C;
				end
				S_DCR_C: begin
					red_dc_q <= dc_new;
					state_q <= S_DCI_B;
				end
				S_DCI_B: begin
					acc_q <= prod_q;
					state_q <= S_DCI_C;
				end
				S_DCI_C: begin
					ir_dc_q <= dc_new;
					d4_q <= dev_q4(d4_src, d4_dc);
					state_q <= S_EN_R;
				end
				S_EN_R: begin
					d4_q <= dev_q4(d4_src, d4_dc);
					state_q <= S_EN_I;
				end
				S_EN_I: begin
					red_e_q <= e_new;
					state_q <= S_EN_DONE;
				end
				S_EN_DONE: begin
					ir_e_q <= e_new;
					if (cnt_next >= {1'b0, len_q}) begin
						wend_q <= 1'b1;
						count_q <= '0;
						if (ir_q < cfg.finger_threshold) begin
							foff_q <= 1'b1;
							state_q <= S_OUT;
						end else begin
							state_q <= S_SQR_GO;
						end
					end else begin
						count_q <= cnt_next[CNT_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_SQR_GO: state_q <= S_SQR_WAIT;
				S_SQR_WAIT: begin
					if (sq_done) begin
						sr_q <= sq_root;
						state_q <= S_SQI_GO;
					end
				end
				S_SQI_GO: state_q <= S_SQI_WAIT;
				S_SQI_WAIT: begin
					if (sq_done) begin
						si_q <= sq_root;
						state_q <= S_FCHK;
					end
				end
				S_FCHK: begin
					if (dcr == '0 || dci == '0 || si_q == '0) begin
						fault_q <= 1'b1;
						red_e_q <= '0;
						ir_e_q <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_MUL_D;
					end
				end
				S_MUL_D: begin
					acc_q <= prod_q;
					state_q <= S_DIV_GO;
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (dv_done) begin
						ratio_q <= dv_quo;
						state_q <= S_RAW_A;
					end
				end
				S_RAW_A: state_q <= S_RAW_B;
				S_RAW_B: begin
					raw_q <= raw_next;
					state_q <= S_SM_A;
				end
				S_SM_A: state_q <= S_SM_B;
				S_SM_B: begin
					acc_q <= prod_q;
					state_q <= S_SM_C;
				end
				S_SM_C: begin
					if (sm_shr > PROD_W'(32767)) begin
						smooth_q <= 16'sh7FFF;
					end else if (sm_shr < -PROD_W'(32768)) begin
						smooth_q <= -16'sh8000;
					end else begin
						smooth_q <= sm_shr[SPO2_W-1:0];
					end
					valid_q <= 1'b1;
					red_e_q <= '0;
					ir_e_q <= '0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						out_wend_q <= wend_q;
						out_foff_q <= foff_q;
						out_est_q <= valid_q;
						out_fault_q <= fault_q;
						out_ratio_q <= ratio_q;
						out_spo2_q <= smooth_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SPO2_ASSERT_SAME(a_est_needs_present_window, res.valid && res.estimate_valid,
		res.window_end && !res.finger_off && !res.divide_fault, "estimate without window")
	`SPO2_ASSERT_SAME(a_flag_needs_window, res.valid && (res.finger_off || res.divide_fault),
		res.window_end, "flag outside window end")
	`SPO2_ASSERT_NEXT(a_busy_after_transfer, accept, !smp.ready, "ready right after transfer")
	`SPO2_ASSERT_SAME(a_count_in_range, 1'b1, 32'(count_q) < MAX_WINDOW, "count out of range")

endmodule
`default_nettype wire

@@ rtl/core/spo2_regs.sv @@
// APB-style configuration register file of the SpO2 ratio estimator.
// Depends on spo2_pkg for register indexes, reset values and cfg_t.
`default_nettype none
module spo2_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [spo2_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [spo2_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [spo2_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output spo2_pkg::cfg_t                   cfg
);
	import spo2_pkg::*;

	cfg_t cfg_q;
	reg_idx_t idx;
	logic wr_en;

	assign idx = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dc_coeff <= RST_DC_COEFF;
			cfg_q.smooth_coeff <= RST_SMOOTH_COEFF;
			cfg_q.finger_threshold <= RST_FINGER_THR;
			cfg_q.window_len <= RST_WINDOW_LEN;
		end else if (wr_en) begin
			unique case (idx)
				REG_DC_COEFF: cfg_q.dc_coeff <= pwdata[COEFF_W-1:0];
				REG_SMOOTH_COEFF: cfg_q.smooth_coeff <= pwdata[COEFF_W-1:0];
				REG_FINGER_THR: cfg_q.finger_threshold <= pwdata[THR_W-1:0];
				REG_WINDOW_LEN: cfg_q.window_len <= pwdata[WLEN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DC_COEFF: prdata = APB_DATA_W'(cfg_q.dc_coeff);
			REG_SMOOTH_COEFF: prdata = APB_DATA_W'(cfg_q.smooth_coeff);
			REG_FINGER_THR: prdata = APB_DATA_W'(cfg_q.finger_threshold);
			REG_WINDOW_LEN: prdata = APB_DATA_W'(cfg_q.window_len);
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/spo2_sqrt.sv @@
// Bit-serial integer square root (floor), one result bit per cycle.
// Depends on spo2_pkg for the energy and root widths.
`default_nettype none
module spo2_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [spo2_pkg::ENERGY_W-1:0] radicand,
	output logic                          done,
	output logic [spo2_pkg::ROOT_W-1:0]   root
);
	import spo2_pkg::*;

	localparam int STEP_W = $clog2(ROOT_W);

	logic [ENERGY_W-1:0] n_q;
	logic [ENERGY_W-1:0] res_q;
	logic [ENERGY_W-1:0] bit_q;
	logic [STEP_W-1:0] step_q;
	logic busy_q;
	logic done_q;
	logic [ENERGY_W:0] trial;
	logic take;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take = {1'b0, n_q} >= trial;
	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				n_q <= radicand;
				res_q <= '0;
				bit_q <= ENERGY_W'(1) << (ENERGY_W - 2);
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (take) begin
					n_q <= n_q - trial[ENERGY_W-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/spo2_div.sv @@
// Restoring divider for the ratio of ratios: floor(num * 2^12 / den) in Q4.12,
// saturated when the quotient reaches 16. Depends on spo2_pkg.
`default_nettype none
module spo2_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [spo2_pkg::NUM_W-1:0]   num,
	input  logic [spo2_pkg::NUM_W-1:0]   den,
	output logic                         done,
	output logic [spo2_pkg::RATIO_W-1:0] quo
);
	import spo2_pkg::*;

	localparam int FRAC = 12;
	localparam int REM_W = NUM_W + FRAC;
	localparam int DSH_W = NUM_W + RATIO_W - 1;
	localparam int STEP_W = $clog2(RATIO_W);

	logic [REM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [RATIO_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic busy_q;
	logic done_q;
	logic take;
	logic too_big;

	assign take = {{(DSH_W - REM_W){1'b0}}, rem_q} >= dsh_q;
	assign too_big = {4'b0, num} >= {den, 4'b0};
	assign done = done_q;
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				if (too_big) begin
					quo_q <= '1;
					done_q <= 1'b1;
				end else begin
					rem_q <= {num, {FRAC{1'b0}}};
					dsh_q <= {den, {(RATIO_W - 1){1'b0}}};
					quo_q <= '0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (take) begin
					rem_q <= rem_q - dsh_q[REM_W-1:0];
				end
				quo_q <= {quo_q[RATIO_W-2:0], take};
				dsh_q <= dsh_q >> 1;
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(RATIO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire
